/* rtl/core/lutt_pkg.sv */
// ----------------------------------------------------------------------------
// lutt_pkg
// Shared types, constants and the lerp and saturation functions of the 3D LUT interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package lutt_pkg;

	localparam int MAX_GRID_DEF = 33;
	localparam int ONE_Q16      = 65536;
	localparam int DIV_STEPS    = 22;   // quotient bits of the grid position
	localparam int CH_N         = 3;
	localparam int ENT_W        = 17;   // UQ1.16 table value
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 1'd1;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] entry_index;
		logic [16:0] entry_r;
		logic [16:0] entry_g;
		logic [16:0] entry_b;
		logic [15:0] pixel_r;
		logic [15:0] pixel_g;
		logic [15:0] pixel_b;
	} in_word_t;

	typedef struct packed {
		logic [15:0] out_r;
		logic [15:0] out_g;
		logic [15:0] out_b;
	} out_word_t;

	typedef struct packed {
		logic idx_w_dummy;
	} unused_t;

	// pipeline control per stage
	typedef struct packed {
		logic vld;
		logic pix;
	} ctl_t;

	// load word carried along the pipe, entry as {b, g, r}
	typedef struct packed {
		logic [15:0]          idx;
		logic [3*ENT_W-1:0]   ent;
	} load_t;

	// one channel of the position divider
	typedef struct packed {
		logic [15:0]          rem;
		logic [DIV_STEPS-1:0] qd;
	} div_t;

	// a + floor((b - a) * w / 65536), w in 0..65536
	function automatic logic [ENT_W-1:0] lerp_q16(input logic [ENT_W-1:0] a,
		input logic [ENT_W-1:0] b, input logic [ENT_W-1:0] w);
		logic signed [17:0] d;
		logic signed [35:0] p;
		logic signed [19:0] s;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = d * $signed({1'b0, w});
		s = $signed({3'b0, a}) + $signed(p[35:16]);
		return s[ENT_W-1:0];
	endfunction

	// saturate a table value to 1.0
	function automatic logic [ENT_W-1:0] sat_one(input logic [ENT_W-1:0] v);
		return (v > ENT_W'(ONE_Q16)) ? ENT_W'(ONE_Q16) : v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/lutt_if.sv */
// ----------------------------------------------------------------------------
// lutt_if
// Valid/ready channels of the 3D LUT interpolator: request, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface lutt_req_if;
	import lutt_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lutt_rsp_if;
	import lutt_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lutt_cfg_if;
	import lutt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/lutt_ram.sv */
// ----------------------------------------------------------------------------
// lutt_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lutt_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr_a,
	input  wire logic [$clog2(D)-1:0] raddr_b,
	output logic      [W-1:0]         rdata_a,
	output logic      [W-1:0]         rdata_b
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/lut3d_trilinear_interpolator_top.sv */
// ----------------------------------------------------------------------------
// lut3d_trilinear_interpolator_top
// 3D colour LUT with trilinear interpolation of RGB pixels.
// ----------------------------------------------------------------------------
// req carries one word per item: a load (req_type 0) writes one table entry,
// a pixel (req_type 1) is interpolated and returns one word on rsp. Loads
// return nothing. cfg writes bit_depth (index 0) and grid_size (index 1); it
// is always ready and the user must write it only while the block is idle,
// which the block itself does not enforce. One word is taken per cycle while
// the output buffer is not full. A pixel passes the divider that finds the
// grid position (one quotient bit per stage), then cell clamp, base address,
// a read of four dual-read copies of the table that yield all eight corners
// at once, three lerp stages and the output scale. Loads write the table in
// the same stage where pixels read it, so stream order is kept without
// forwarding. The result leaves through a two-word buffer; the pipe stops
// only when that buffer is full, so an item is still taken while one result
// waits. At reset all pipe and buffer valid bits clear and the registers go
// to bit_depth 8, grid_size 33. Table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module lut3d_trilinear_interpolator_top
	import lutt_pkg::*;
#(
	parameter int MAX_GRID = MAX_GRID_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lutt_req_if.sink  req,
	lutt_rsp_if.source rsp,
	lutt_cfg_if.sink  cfg
);

	localparam int LUT_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
	localparam int AW        = $clog2(LUT_DEPTH);

	// ---------------- configuration ----------------
	logic [4:0]  bit_depth_q;
	logic [5:0]  grid_size_q;
	logic [4:0]  depth;
	logic [5:0]  size;
	logic [15:0] maxcode;
	logic [11:0] sz_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q <= 5'd8;
			grid_size_q <= 6'd33;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BIT_DEPTH: bit_depth_q <= cfg.data[4:0];
				REG_GRID_SIZE: grid_size_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bit_depth_q == 5'd0) depth = 5'd1;
		else if (bit_depth_q > 5'd16) depth = 5'd16;
		else depth = bit_depth_q;
		if (grid_size_q < 6'd2) size = 6'd2;
		else if (int'(grid_size_q) > MAX_GRID) size = 6'(MAX_GRID);
		else size = grid_size_q;
		maxcode = 16'((17'd1 << depth) - 17'd1);
	end

	always_ff @(posedge clk) begin
		sz_q <= 12'(size) * 12'(size);
	end

	// ---------------- flow control ----------------
	out_word_t fifo_q [2];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic      en, push, pop;

	assign en        = (cnt_q != 2'd2);
	assign req.ready = en;

	// ---------------- stage 1 and divider ----------------
	ctl_t  ctl_sd [DIV_STEPS+1];
	load_t ld_sd  [DIV_STEPS+1];
	div_t  dv_sd  [DIV_STEPS+1][CH_N];

	logic [15:0] code_in [CH_N];
	logic [21:0] n_in    [CH_N];

	always_comb begin
		code_in[0] = req.data.pixel_r;
		code_in[1] = req.data.pixel_g;
		code_in[2] = req.data.pixel_b;
		for (int ch = 0; ch < CH_N; ch++) begin
			if (code_in[ch] > maxcode) code_in[ch] = maxcode;
			n_in[ch] = 22'(code_in[ch]) * 22'(size - 6'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sd[0] <= '0;
		end else if (en) begin
			ctl_sd[0].vld <= req.valid;
			ctl_sd[0].pix <= req.data.req_type == REQ_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld_sd[0].idx <= req.data.entry_index;
			ld_sd[0].ent <= {sat_one(req.data.entry_b), sat_one(req.data.entry_g),
				sat_one(req.data.entry_r)};
			for (int ch = 0; ch < CH_N; ch++) begin
				dv_sd[0][ch].rem <= n_in[ch][21:6];
				dv_sd[0][ch].qd  <= {n_in[ch][5:0], 16'd0};
			end
		end
	end

	// restoring division by 2^depth-1, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		div_t nx [CH_N];

		always_comb begin
			logic [16:0] r2;
			logic        ge;
			for (int ch = 0; ch < CH_N; ch++) begin
				r2 = {dv_sd[k][ch].rem, dv_sd[k][ch].qd[DIV_STEPS-1]};
				ge = r2 >= {1'b0, maxcode};
				nx[ch].rem = ge ? 16'(r2 - {1'b0, maxcode}) : r2[15:0];
				nx[ch].qd  = {dv_sd[k][ch].qd[DIV_STEPS-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sd[k+1] <= '0;
			end else if (en) begin
				ctl_sd[k+1] <= ctl_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ld_sd[k+1] <= ld_sd[k];
				dv_sd[k+1] <= nx;
			end
		end
	end

	// ---------------- cell and weight ----------------
	ctl_t        ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	load_t       ld_s2, ld_s3;
	logic [5:0]  cell_s2 [CH_N];
	logic [16:0] w_s2    [CH_N];
	logic [16:0] w_s3    [CH_N];
	logic [AW-1:0] base_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_sd[DIV_STEPS];
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		logic [5:0] ip;
		if (en) begin
			ld_s2 <= ld_sd[DIV_STEPS];
			for (int ch = 0; ch < CH_N; ch++) begin
				ip = dv_sd[DIV_STEPS][ch].qd[21:16];
				// top code: stay in the last cell at full weight
				if (ip >= size - 6'd1) begin
					cell_s2[ch] <= size - 6'd2;
					w_s2[ch]    <= 17'(ONE_Q16);
				end else begin
					cell_s2[ch] <= ip;
					w_s2[ch]    <= {1'b0, dv_sd[DIV_STEPS][ch].qd[15:0]};
				end
			end
		end
	end

	// ---------------- base address ----------------
	always_ff @(posedge clk) begin
		logic [31:0] b;
		if (en) begin
			b = 32'(cell_s2[2]) * 32'(sz_q) + 32'(cell_s2[1]) * 32'(size)
				+ 32'(cell_s2[0]);
			base_s3 <= b[AW-1:0];
			ld_s3   <= ld_s2;
			w_s3    <= w_s2;
		end
	end

	// ---------------- table read and load write ----------------
	logic [AW-1:0] sy, sz;
	logic [AW-1:0] ra [4];
	logic [AW-1:0] rb [4];
	logic [3*ENT_W-1:0] rd_a [4];
	logic [3*ENT_W-1:0] rd_b [4];
	logic          we;

	assign sy = AW'(size);
	assign sz = AW'(sz_q);

	always_comb begin
		ra[0] = base_s3;
		ra[1] = base_s3 + sy;
		ra[2] = base_s3 + sz;
		ra[3] = base_s3 + sz + sy;
		for (int i = 0; i < 4; i++) begin
			rb[i] = ra[i] + AW'(1);
		end
	end

	assign we = en && ctl_s3.vld && (ctl_s3.pix == REQ_LOAD)
		&& (32'(ld_s3.idx) < LUT_DEPTH);

	for (genvar i = 0; i < 4; i++) begin : g_ram
		lutt_ram #(
			.W (3 * ENT_W),
			.D (LUT_DEPTH)
		) u_ram (
			.clk     (clk),
			.we      (we),
			.waddr   (AW'(ld_s3.idx)),
			.wdata   (ld_s3.ent),
			.re      (en),
			.raddr_a (ra[i]),
			.raddr_b (rb[i]),
			.rdata_a (rd_a[i]),
			.rdata_b (rd_b[i])
		);
	end

	// ---------------- lerps ----------------
	logic [16:0] w_s4 [CH_N];
	logic [16:0] wy_s5, wz_s5, wz_s6;
	logic [16:0] e_s5 [CH_N][4];
	logic [16:0] f_s6 [CH_N][2];
	logic [16:0] c_s7 [CH_N];

	always_ff @(posedge clk) begin
		if (en) begin
			w_s4  <= w_s3;
			wy_s5 <= w_s4[1];
			wz_s5 <= w_s4[2];
			wz_s6 <= wz_s5;
			for (int ch = 0; ch < CH_N; ch++) begin
				for (int i = 0; i < 4; i++) begin
					e_s5[ch][i] <= lerp_q16(rd_a[i][ch*ENT_W +: ENT_W],
						rd_b[i][ch*ENT_W +: ENT_W], w_s4[0]);
				end
				f_s6[ch][0] <= lerp_q16(e_s5[ch][0], e_s5[ch][1], wy_s5);
				f_s6[ch][1] <= lerp_q16(e_s5[ch][2], e_s5[ch][3], wy_s5);
				c_s7[ch]    <= lerp_q16(f_s6[ch][0], f_s6[ch][1], wz_s6);
			end
		end
	end

	// ---------------- scale and output buffer ----------------
	logic [15:0] code_out [CH_N];

	always_comb begin
		logic [32:0] p;
		for (int ch = 0; ch < CH_N; ch++) begin
			p = 33'(c_s7[ch]) * 33'(maxcode);
			code_out[ch] = p[31:16];
		end
	end

	assign push = en && ctl_s7.vld && (ctl_s7.pix == REQ_PIXEL);
	assign pop  = rsp.valid && rsp.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{out_r: code_out[0], out_g: code_out[1],
				out_b: code_out[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign rsp.valid = (cnt_q != 2'd0);
	assign rsp.data  = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

/* rtl/core/lutt_checker.sv */
// ----------------------------------------------------------------------------
// lutt_checker
// Port-level checks of the 3D LUT interpolator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lutt_checker
	import lutt_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_ready,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire out_word_t rsp_data,
	input wire logic      cfg_ready
);

	// a held result word does not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word changed while stalled");

	// the pipe only stops when results are backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("input stalled with no result pending");

	// taking a result always frees room for input next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |=> req_ready)
		else $error("input still stalled after a result was taken");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind lut3d_trilinear_interpolator_top lutt_checker u_lutt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data),
	.cfg_ready (cfg.ready)
);

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the 3D LUT trilinear interpolator: table loads and
// pixels are predicted in the bench and every result word is compared in order.
// ----------------------------------------------------------------------------

module tb_top;
	import lutt_pkg::*;

	localparam int STORE_N    = 35937;
	localparam int DRAIN_WAIT = 40;
	localparam int CYCLE_MAX  = 2000000;
	localparam int N_PHASE    = 9;
	localparam int PER_PHASE  = 24;

	logic clk;
	logic arst_n;

	lutt_req_if req_ch ();
	lutt_rsp_if rsp_ch ();
	lutt_cfg_if cfg_ch ();

	lut3d_trilinear_interpolator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the table and registers
	logic [16:0] lut_tab [3][STORE_N];
	bit          filled  [STORE_N];
	logic [4:0]  depth_reg;
	logic [5:0]  size_reg;

	in_word_t  pend_words [$];
	out_word_t exp_pixels [$];
	int        src_idle;
	int        snk_idle;
	int        errors;
	int        n_pix;
	int        n_load;
	int        n_cfg;
	longint    cycles;

	function automatic logic [16:0] sat_val(input logic [16:0] v);
		return (v > 17'd65536) ? 17'd65536 : v;
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		longint p;
		longint q;
		p = (b - a) * w;
		if (p >= 0) begin
			q = p >>> 16;
		end else begin
			q = -((-p + 65535) >>> 16);
		end
		return a + q;
	endfunction

	task automatic locate(input longint code, input longint maxc, input longint sz,
		output int cidx, output longint w);
		longint pos;
		if (code > maxc) begin
			code = maxc;
		end
		pos = (code * (sz - 1) * ONE_Q16) / maxc;
		if ((pos >> 16) >= sz - 1) begin
			cidx = int'(sz - 2);
			w    = ONE_Q16;
		end else begin
			cidx = int'(pos >> 16);
			w    = pos & 16'hFFFF;
		end
	endtask

	// applies one accepted word to the bench state
	task automatic apply_word(input in_word_t wd);
		int        sz;
		int        dp;
		longint    maxc;
		int        cx, cy, cz;
		longint    wx, wy, wz;
		int        base, sz2;
		longint    e00, e10, e01, e11, f0, f1, c;
		longint    res [3];
		out_word_t ow;
		if (wd.req_type == REQ_LOAD) begin
			if (wd.entry_index < STORE_N) begin
				lut_tab[0][wd.entry_index] = sat_val(wd.entry_r);
				lut_tab[1][wd.entry_index] = sat_val(wd.entry_g);
				lut_tab[2][wd.entry_index] = sat_val(wd.entry_b);
			end
			n_load++;
		end else begin
			sz   = (size_reg < 2) ? 2 : (size_reg > 33) ? 33 : size_reg;
			dp   = (depth_reg < 1) ? 1 : (depth_reg > 16) ? 16 : depth_reg;
			maxc = (longint'(1) << dp) - 1;
			locate(wd.pixel_r, maxc, sz, cx, wx);
			locate(wd.pixel_g, maxc, sz, cy, wy);
			locate(wd.pixel_b, maxc, sz, cz, wz);
			sz2  = sz * sz;
			base = cz * sz2 + cy * sz + cx;
			for (int ch = 0; ch < 3; ch++) begin
				e00 = blend(lut_tab[ch][base], lut_tab[ch][base + 1], wx);
				e10 = blend(lut_tab[ch][base + sz], lut_tab[ch][base + sz + 1], wx);
				e01 = blend(lut_tab[ch][base + sz2], lut_tab[ch][base + sz2 + 1], wx);
				e11 = blend(lut_tab[ch][base + sz2 + sz],
					lut_tab[ch][base + sz2 + sz + 1], wx);
				f0  = blend(e00, e10, wy);
				f1  = blend(e01, e11, wy);
				c   = blend(f0, f1, wz);
				res[ch] = ((c * maxc) >> 16) & 16'hFFFF;
			end
			ow.out_r = 16'(res[0]);
			ow.out_g = 16'(res[1]);
			ow.out_b = 16'(res[2]);
			exp_pixels.push_back(ow);
			n_pix++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				apply_word(req_ch.data);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pend_words.size() > 0 && $urandom_range(99) >= src_idle) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= pend_words.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (exp_pixels.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time,
						rsp_ch.data);
					errors++;
				end else begin
					out_word_t ew;
					ew = exp_pixels.pop_front();
					if (rsp_ch.data.out_r !== ew.out_r) begin
						$display("%0t: out_r expected %0d actual %0d", $time, ew.out_r,
							rsp_ch.data.out_r);
						errors++;
					end
					if (rsp_ch.data.out_g !== ew.out_g) begin
						$display("%0t: out_g expected %0d actual %0d", $time, ew.out_g,
							rsp_ch.data.out_g);
						errors++;
					end
					if (rsp_ch.data.out_b !== ew.out_b) begin
						$display("%0t: out_b expected %0d actual %0d", $time, ew.out_b,
							rsp_ch.data.out_b);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic in_word_t mk_load(input int idx, input logic [16:0] r,
		input logic [16:0] g, input logic [16:0] b);
		in_word_t wd;
		wd             = '0;
		wd.req_type    = REQ_LOAD;
		wd.entry_index = 16'(idx);
		wd.entry_r     = r;
		wd.entry_g     = g;
		wd.entry_b     = b;
		wd.pixel_r     = 16'($urandom());
		wd.pixel_g     = 16'($urandom());
		wd.pixel_b     = 16'($urandom());
		return wd;
	endfunction

	function automatic in_word_t mk_pixel(input int r, input int g, input int b);
		in_word_t wd;
		wd             = '0;
		wd.req_type    = REQ_PIXEL;
		wd.entry_index = 16'($urandom());
		wd.entry_r     = 17'($urandom());
		wd.entry_g     = 17'($urandom());
		wd.entry_b     = 17'($urandom());
		wd.pixel_r     = 16'(r);
		wd.pixel_g     = 16'(g);
		wd.pixel_b     = 16'(b);
		return wd;
	endfunction

	function automatic logic [16:0] rnd_entry();
		int k;
		k = $urandom_range(99);
		if (k < 4) return 17'd65536;
		if (k < 7) return 17'($urandom_range(17'h1FFFF, 65537));
		if (k < 10) return 17'd0;
		return 17'($urandom_range(65536));
	endfunction

	// queues a load and marks the entry as written
	task automatic push_load(input int idx, input logic [16:0] r, input logic [16:0] g,
		input logic [16:0] b);
		pend_words.push_back(mk_load(idx, r, g, b));
		if (idx < STORE_N) begin
			filled[idx] = 1'b1;
		end
	endtask

	// queues a pixel after loading any of its eight corners not yet written
	task automatic push_pixel(input int r, input int g, input int b);
		int     sz;
		int     dp;
		longint maxc;
		int     cx, cy, cz;
		longint wx, wy, wz;
		int     idx;
		sz   = (size_reg < 2) ? 2 : (size_reg > 33) ? 33 : size_reg;
		dp   = (depth_reg < 1) ? 1 : (depth_reg > 16) ? 16 : depth_reg;
		maxc = (longint'(1) << dp) - 1;
		locate(r, maxc, sz, cx, wx);
		locate(g, maxc, sz, cy, wy);
		locate(b, maxc, sz, cz, wz);
		for (int dz = 0; dz < 2; dz++) begin
			for (int dy = 0; dy < 2; dy++) begin
				for (int dx = 0; dx < 2; dx++) begin
					idx = (cz + dz) * sz * sz + (cy + dy) * sz + cx + dx;
					if (!filled[idx]) begin
						push_load(idx, rnd_entry(), rnd_entry(), rnd_entry());
					end
				end
			end
		end
		pend_words.push_back(mk_pixel(r, g, b));
	endtask

	// codes mostly in the first and last cell of each axis
	function automatic int rnd_code();
		int dp;
		int sz;
		int maxc;
		int span;
		int k;
		dp   = (depth_reg < 1) ? 1 : (depth_reg > 16) ? 16 : depth_reg;
		sz   = (size_reg < 2) ? 2 : (size_reg > 33) ? 33 : size_reg;
		maxc = (1 << dp) - 1;
		span = maxc / (sz - 1);
		k    = $urandom_range(99);
		if (k < 10) return 0;
		if (k < 25) return maxc;
		if (k < 35) return int'($urandom_range(65535, maxc));
		if (k < 65) return int'($urandom_range(span));
		if (k < 95) return int'($urandom_range(maxc, maxc - span));
		return int'($urandom_range(maxc));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		forever begin
			@(posedge clk);
			if (cfg_ch.ready) break;
		end
		cfg_ch.valid <= 1'b0;
		if (idx == REG_BIT_DEPTH) begin
			depth_reg = val[4:0];
		end else begin
			size_reg = val;
		end
		n_cfg++;
	endtask

	task automatic drain();
		while (pend_words.size() > 0 || req_ch.valid || exp_pixels.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// depth and size per phase, out-of-range writes included
	int set_depth [N_PHASE] = '{8, 16, 1, 10, 0, 31, 12, 16, 5};
	int set_size  [N_PHASE] = '{33, 33, 2, 5, 1, 63, 17, 2, 33};

	initial begin
		int sz;
		int k;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		errors       = 0;
		n_pix        = 0;
		n_load       = 0;
		n_cfg        = 0;
		cycles       = 0;
		depth_reg    = 5'd8;
		size_reg     = 6'd33;
		src_idle     = 30;
		snk_idle     = 66;
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < STORE_N; i++) lut_tab[ch][i] = '0;
		end
		for (int i = 0; i < STORE_N; i++) filled[i] = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings
		push_load(STORE_N, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		push_load(16'hFFFF, 17'd0, 17'd0, 17'd0);
		push_load(STORE_N - 1, 17'h1FFFF, 17'd65536, 17'd0);
		push_load(0, 17'd0, 17'd65536, 17'h10001);
		push_load(1, 17'd65536, 17'd0, 17'd12345);
		push_pixel(0, 0, 0);
		push_pixel(255, 255, 255);
		push_pixel(1, 0, 0);
		push_pixel(254, 254, 254);
		push_pixel(255, 0, 128);
		push_pixel(65535, 65535, 65535);
		push_pixel(256, 1000, 0);
		push_pixel(0, 128, 255);
		push_pixel(127, 63, 191);
		push_pixel(8, 16, 32);

		for (int ph = 0; ph < N_PHASE; ph++) begin
			if (ph > 0) begin
				drain();
				if (ph == 3) begin
					src_idle = 66;
					snk_idle = 30;
				end else if (ph == 6) begin
					src_idle = 0;
					snk_idle = 0;
				end
				write_reg(REG_BIT_DEPTH, 6'(set_depth[ph]));
				write_reg(REG_GRID_SIZE, 6'(set_size[ph]));
			end
			sz = (size_reg < 2) ? 2 : (size_reg > 33) ? 33 : size_reg;
			for (int n = 0; n < PER_PHASE; n++) begin
				k = $urandom_range(99);
				if (k < 75) begin
					push_pixel(rnd_code(), rnd_code(), rnd_code());
				end else if (k < 95) begin
					// reload an entry inside the active grid
					push_load(int'($urandom_range(sz * sz * sz - 1)),
						rnd_entry(), rnd_entry(), rnd_entry());
				end else begin
					push_load(int'($urandom_range(65535, STORE_N)),
						rnd_entry(), rnd_entry(), rnd_entry());
					n--;
				end
			end
		end
		drain();

		$display("covered %0d pixels, %0d table loads, %0d register writes", n_pix,
			n_load, n_cfg);
		$display("depths 0..31 and grid sizes 1..63 incl. clamps, three stall mixes");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* lut3d_trilinear_interpolator_top.f */
rtl/core/lutt_pkg.sv
rtl/core/lutt_if.sv
rtl/core/lutt_ram.sv
rtl/core/lut3d_trilinear_interpolator_top.sv
rtl/core/lutt_checker.sv
verif/tb_top.sv
